// ===== src/sbec_pkg.sv =====
// Shared types and constants for the SPI bus edge capture block.
// Used by spi_bus_edge_capture.sv; depends on nothing else.

package sbec_pkg;

    // Ring depths; the address arithmetic wraps by truncation, so these stay powers of two.
    localparam int EDGE_SLOTS  = 512;
    localparam int FRAME_DEPTH = 128;
    localparam int BYTE_SLOTS  = 1024;

    localparam int EDGE_AW  = $clog2(EDGE_SLOTS);
    localparam int FRAME_AW = $clog2(FRAME_DEPTH);
    localparam int BYTE_AW  = $clog2(BYTE_SLOTS);

    localparam int EDGE_HW  = EDGE_AW + 1;
    localparam int FRAME_HW = FRAME_AW + 1;
    localparam int BYTE_HW  = BYTE_AW + 1;

    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 16;
    localparam int POS_W  = 10;
    localparam int HELD_W = 11;
    localparam int VAL_W  = 16;

    // Entry layouts: edge = {level, line, time}, frame = {len, end, start}.
    localparam int EDGE_W  = TIME_W + 3;
    localparam int FRAME_W = 2 * TIME_W + LEN_W;
    localparam int BYTE_W  = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 224;

    localparam logic [2:0] REQ_EDGE    = 3'd0;
    localparam logic [2:0] REQ_RD_EDGE = 3'd1;
    localparam logic [2:0] REQ_RD_FRM  = 3'd2;
    localparam logic [2:0] REQ_RD_BYTE = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam logic [1:0] LINE_CS   = 2'd0;
    localparam logic [1:0] LINE_SCK  = 2'd1;
    localparam logic [1:0] LINE_MOSI = 2'd2;

    typedef struct packed {
        logic              read_ok;
        logic [TIME_W-1:0] read_time;
        logic [TIME_W-1:0] read_time_end;
        logic [1:0]        read_line;
        logic              read_level;
        logic [VAL_W-1:0]  read_value;
        logic [HELD_W-1:0] held_entries;
        logic [CNT_W-1:0]  total_edges;
        logic [CNT_W-1:0]  total_bytes;
        logic [CNT_W-1:0]  total_frames;
        logic [CNT_W-1:0]  total_drops;
        logic              spi_seen;
    } res_t;

endpackage

// ===== src/sbec_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// Generic; used by spi_bus_edge_capture for the three rings.

module sbec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/spi_bus_edge_capture.sv =====
// SPI bus edge capture: one request word per cycle while s_tready is high, three RAM rings (two timestamped).
// Depends on sbec_pkg and sbec_ram.
//
// The block takes one request word per clock and returns one result word for each, in order,
// through the result stage and the output queue as m_tready allows. Ring pointers, fill levels,
// counters and the SPI decoder live in flip-flops and are updated in the accept cycle; each
// ring is a RAM with one write and one registered read port, so a read lands in the cycle after
// acceptance in a result stage that feeds a three-word output queue. s_tready depends only on that
// queue and the result stage, and stays high at full rate while m_tready is high. Entries never
// written are never readable, so the rings need no clearing pass after reset or clear.

module spi_bus_edge_capture (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,    // capture_on
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // line_id[1:0], line_level[2], time_us[34:3], read_pos[44:35], zero pad
    input  logic [sbec_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [2:0]                         s_tuser,      // req_type[2:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_ok[0], read_time[32:1], read_time_end[64:33], read_line[66:65], read_level[67],
    // read_value[83:68], held_entries[94:84], total_edges[126:95], total_bytes[158:127],
    // total_frames[190:159], total_drops[222:191], spi_seen[223]
    output logic [sbec_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int EAW = sbec_pkg::EDGE_AW;
    localparam int FAW = sbec_pkg::FRAME_AW;
    localparam int BAW = sbec_pkg::BYTE_AW;
    localparam int EHW = sbec_pkg::EDGE_HW;
    localparam int FHW = sbec_pkg::FRAME_HW;
    localparam int BHW = sbec_pkg::BYTE_HW;
    localparam int CW  = sbec_pkg::CNT_W;
    localparam int TW  = sbec_pkg::TIME_W;
    localparam int LW  = sbec_pkg::LEN_W;
    localparam int HW  = sbec_pkg::HELD_W;

    // Input fields.
    logic [2:0]                 req;
    logic [1:0]                 line;
    logic                       level;
    logic [TW-1:0]              t_us;
    logic [sbec_pkg::POS_W-1:0] pos;
    logic                       s_accept;

    assign req   = s_tuser;
    assign line  = s_tdata[1:0];
    assign level = s_tdata[2];
    assign t_us  = s_tdata[34:3];
    assign pos   = s_tdata[44:35];
    assign s_accept = s_tvalid && s_tready;

    // Ring pointers and fill levels.
    logic [EAW-1:0] edge_next_reg,  edge_next_next;
    logic [EHW-1:0] edge_held_reg,  edge_held_next;
    logic [FAW-1:0] frame_next_reg, frame_next_next;
    logic [FHW-1:0] frame_held_reg, frame_held_next;
    logic [BAW-1:0] byte_next_reg,  byte_next_next;
    logic [BHW-1:0] byte_held_reg,  byte_held_next;

    // Counters.
    logic [CW-1:0] edges_reg,  edges_next;
    logic [CW-1:0] bytes_reg,  bytes_next;
    logic [CW-1:0] frames_reg, frames_next;
    logic [CW-1:0] drops_reg,  drops_next;

    // Decoder state.
    logic          capture_reg,   capture_next;
    logic          open_reg,      open_next;
    logic [TW-1:0] open_time_reg, open_time_next;
    logic [LW-1:0] at_open_reg,   at_open_next;
    logic          mosi_reg,      mosi_next;
    logic [7:0]    shift_reg,     shift_next;
    logic [2:0]    bit_cnt_reg,   bit_cnt_next;
    logic          cs_reg,        cs_next;
    logic          spi_reg,       spi_next;

    // RAM ports.
    logic                          edge_we,  edge_re;
    logic [EAW-1:0]                edge_waddr, edge_raddr;
    logic [sbec_pkg::EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic                          frame_we, frame_re;
    logic [FAW-1:0]                frame_waddr, frame_raddr;
    logic [sbec_pkg::FRAME_W-1:0]  frame_wdata, frame_rdata;
    logic                          byte_we,  byte_re;
    logic [BAW-1:0]                byte_waddr, byte_raddr;
    logic [sbec_pkg::BYTE_W-1:0]   byte_wdata, byte_rdata;

    // Result stage.
    logic       s1_valid_reg;
    logic [2:0] s1_kind_reg, s1_kind_next;
    logic       s1_ok_reg,   s1_ok_next;

    logic [7:0] shift_in;
    assign shift_in = {shift_reg[6:0], mosi_reg};

    always_comb begin
        edge_next_next  = edge_next_reg;
        edge_held_next  = edge_held_reg;
        frame_next_next = frame_next_reg;
        frame_held_next = frame_held_reg;
        byte_next_next  = byte_next_reg;
        byte_held_next  = byte_held_reg;
        edges_next      = edges_reg;
        bytes_next      = bytes_reg;
        frames_next     = frames_reg;
        drops_next      = drops_reg;
        capture_next    = capture_reg;
        open_next       = open_reg;
        open_time_next  = open_time_reg;
        at_open_next    = at_open_reg;
        mosi_next       = mosi_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        cs_next         = cs_reg;
        spi_next        = spi_reg;

        edge_we     = 1'b0;
        edge_waddr  = edge_next_reg;
        edge_wdata  = {level, line, t_us};
        frame_we    = 1'b0;
        frame_waddr = frame_next_reg;
        frame_wdata = {bytes_reg[LW-1:0] - at_open_reg, t_us, open_time_reg};
        byte_we     = 1'b0;
        byte_waddr  = byte_next_reg;
        byte_wdata  = shift_in;

        edge_re    = 1'b0;
        edge_raddr = edge_next_reg - EAW'(edge_held_reg) + EAW'(pos);
        frame_re   = 1'b0;
        frame_raddr = frame_next_reg - FAW'(frame_held_reg) + FAW'(pos);
        byte_re    = 1'b0;
        byte_raddr = byte_next_reg - BAW'(byte_held_reg) + BAW'(pos);

        s1_kind_next = req;
        s1_ok_next   = 1'b0;

        if (cfg_we) begin
            capture_next = cfg_wdata;
            open_next    = 1'b0;
            shift_next   = 8'd0;
            bit_cnt_next = 3'd0;
            cs_next      = 1'b1;
        end else if (s_accept) begin
            case (req)
                sbec_pkg::REQ_EDGE: begin
                    if (capture_reg) begin
                        edge_we        = 1'b1;
                        edge_next_next = edge_next_reg + EAW'(1);
                        if (edge_held_reg == EHW'(sbec_pkg::EDGE_SLOTS)) begin
                            drops_next = drops_next + CW'(1);
                        end else begin
                            edge_held_next = edge_held_reg + EHW'(1);
                        end
                        edges_next = edges_reg + CW'(1);

                        if (line == sbec_pkg::LINE_MOSI) begin
                            mosi_next = level;
                        end else if (line == sbec_pkg::LINE_CS) begin
                            if (cs_reg && !level) begin
                                open_next      = 1'b1;
                                open_time_next = t_us;
                                at_open_next   = bytes_reg[LW-1:0];
                                shift_next     = 8'd0;
                                bit_cnt_next   = 3'd0;
                                spi_next       = 1'b1;
                            end else if (!cs_reg && level && open_reg) begin
                                frame_we        = 1'b1;
                                frame_next_next = frame_next_reg + FAW'(1);
                                if (frame_held_reg == FHW'(sbec_pkg::FRAME_DEPTH)) begin
                                    drops_next = drops_next + CW'(1);
                                end else begin
                                    frame_held_next = frame_held_reg + FHW'(1);
                                end
                                frames_next = frames_reg + CW'(1);
                                open_next   = 1'b0;
                            end
                            cs_next = level;
                        end else if (line == sbec_pkg::LINE_SCK && open_reg && level) begin
                            // The eighth bit completes a byte and restarts the shifter.
                            if (bit_cnt_reg == 3'd7) begin
                                byte_we        = 1'b1;
                                byte_next_next = byte_next_reg + BAW'(1);
                                if (byte_held_reg == BHW'(sbec_pkg::BYTE_SLOTS)) begin
                                    drops_next = drops_next + CW'(1);
                                end else begin
                                    byte_held_next = byte_held_reg + BHW'(1);
                                end
                                bytes_next   = bytes_reg + CW'(1);
                                shift_next   = 8'd0;
                                bit_cnt_next = 3'd0;
                            end else begin
                                shift_next   = shift_in;
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                            end
                        end
                    end
                end
                sbec_pkg::REQ_RD_EDGE: begin
                    s1_ok_next = {1'b0, pos} < HW'(edge_held_reg);
                    edge_re    = 1'b1;
                end
                sbec_pkg::REQ_RD_FRM: begin
                    s1_ok_next = {1'b0, pos} < HW'(frame_held_reg);
                    frame_re   = 1'b1;
                end
                sbec_pkg::REQ_RD_BYTE: begin
                    s1_ok_next = {1'b0, pos} < HW'(byte_held_reg);
                    byte_re    = 1'b1;
                end
                sbec_pkg::REQ_CLEAR: begin
                    edge_next_next  = '0;
                    edge_held_next  = '0;
                    frame_next_next = '0;
                    frame_held_next = '0;
                    byte_next_next  = '0;
                    byte_held_next  = '0;
                    edges_next      = '0;
                    bytes_next      = '0;
                    frames_next     = '0;
                    drops_next      = '0;
                    open_next       = 1'b0;
                    open_time_next  = '0;
                    at_open_next    = '0;
                    mosi_next       = 1'b0;
                    shift_next      = 8'd0;
                    bit_cnt_next    = 3'd0;
                    cs_next         = 1'b1;
                    spi_next        = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    sbec_ram #(.WIDTH(sbec_pkg::EDGE_W), .DEPTH(sbec_pkg::EDGE_SLOTS)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    sbec_ram #(.WIDTH(sbec_pkg::FRAME_W), .DEPTH(sbec_pkg::FRAME_DEPTH)) u_frame_ram (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    sbec_ram #(.WIDTH(sbec_pkg::BYTE_W), .DEPTH(sbec_pkg::BYTE_SLOTS)) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    // Output queue, three words deep so that acceptance never waits on m_tready directly.
    sbec_pkg::res_t q_mem [3];
    logic [1:0]     q_wr_reg, q_rd_reg, q_cnt_reg;
    logic           q_pop;
    sbec_pkg::res_t s1_res;

    assign q_pop    = m_tvalid && m_tready;
    assign m_tvalid = q_cnt_reg != 2'd0;
    assign s_tready = s1_valid_reg ? (q_cnt_reg < 2'd2) : (q_cnt_reg < 2'd3);

    // Counters and fill levels already hold the post-step values while the word sits here.
    always_comb begin
        s1_res               = '0;
        s1_res.read_ok       = s1_ok_reg;
        s1_res.total_edges   = edges_reg;
        s1_res.total_bytes   = bytes_reg;
        s1_res.total_frames  = frames_reg;
        s1_res.total_drops   = drops_reg;
        s1_res.spi_seen      = spi_reg;
        case (s1_kind_reg)
            sbec_pkg::REQ_EDGE: begin
                s1_res.held_entries = HW'(edge_held_reg);
            end
            sbec_pkg::REQ_RD_EDGE: begin
                s1_res.held_entries = HW'(edge_held_reg);
                if (s1_ok_reg) begin
                    s1_res.read_time  = edge_rdata[TW-1:0];
                    s1_res.read_line  = edge_rdata[TW+1:TW];
                    s1_res.read_level = edge_rdata[TW+2];
                end
            end
            sbec_pkg::REQ_RD_FRM: begin
                s1_res.held_entries = HW'(frame_held_reg);
                if (s1_ok_reg) begin
                    s1_res.read_time     = frame_rdata[TW-1:0];
                    s1_res.read_time_end = frame_rdata[2*TW-1:TW];
                    s1_res.read_value    = frame_rdata[2*TW+LW-1:2*TW];
                end
            end
            sbec_pkg::REQ_RD_BYTE: begin
                s1_res.held_entries = HW'(byte_held_reg);
                if (s1_ok_reg) begin
                    s1_res.read_value = sbec_pkg::VAL_W'(byte_rdata);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_next_reg  <= '0;
            edge_held_reg  <= '0;
            frame_next_reg <= '0;
            frame_held_reg <= '0;
            byte_next_reg  <= '0;
            byte_held_reg  <= '0;
            edges_reg      <= '0;
            bytes_reg      <= '0;
            frames_reg     <= '0;
            drops_reg      <= '0;
            capture_reg    <= 1'b0;
            open_reg       <= 1'b0;
            open_time_reg  <= '0;
            at_open_reg    <= '0;
            mosi_reg       <= 1'b0;
            shift_reg      <= 8'd0;
            bit_cnt_reg    <= 3'd0;
            cs_reg         <= 1'b1;
            spi_reg        <= 1'b0;
            s1_valid_reg   <= 1'b0;
            q_wr_reg       <= 2'd0;
            q_rd_reg       <= 2'd0;
            q_cnt_reg      <= 2'd0;
        end else begin
            edge_next_reg  <= edge_next_next;
            edge_held_reg  <= edge_held_next;
            frame_next_reg <= frame_next_next;
            frame_held_reg <= frame_held_next;
            byte_next_reg  <= byte_next_next;
            byte_held_reg  <= byte_held_next;
            edges_reg      <= edges_next;
            bytes_reg      <= bytes_next;
            frames_reg     <= frames_next;
            drops_reg      <= drops_next;
            capture_reg    <= capture_next;
            open_reg       <= open_next;
            open_time_reg  <= open_time_next;
            at_open_reg    <= at_open_next;
            mosi_reg       <= mosi_next;
            shift_reg      <= shift_next;
            bit_cnt_reg    <= bit_cnt_next;
            cs_reg         <= cs_next;
            spi_reg        <= spi_next;
            s1_valid_reg   <= s_accept;
            if (s1_valid_reg) begin
                q_wr_reg <= (q_wr_reg == 2'd2) ? 2'd0 : q_wr_reg + 2'd1;
            end
            if (q_pop) begin
                q_rd_reg <= (q_rd_reg == 2'd2) ? 2'd0 : q_rd_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg <= s1_kind_next;
            s1_ok_reg   <= s1_ok_next;
        end
        if (s1_valid_reg) begin
            q_mem[q_wr_reg] <= s1_res;
        end
    end

    sbec_pkg::res_t q_head;
    assign q_head = q_mem[q_rd_reg];

    assign m_tdata = {q_head.spi_seen, q_head.total_drops, q_head.total_frames,
                      q_head.total_bytes, q_head.total_edges, q_head.held_entries,
                      q_head.read_value, q_head.read_level, q_head.read_line,
                      q_head.read_time_end, q_head.read_time, q_head.read_ok};

    // A word entering the result stage must always find room in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_valid_reg && q_cnt_reg == 2'd3 && !q_pop))
        else $error("output queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> s1_valid_reg)
        else $error("accepted word did not reach the result stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        edge_held_reg <= EHW'(sbec_pkg::EDGE_SLOTS) &&
        frame_held_reg <= FHW'(sbec_pkg::FRAME_DEPTH) &&
        byte_held_reg <= BHW'(sbec_pkg::BYTE_SLOTS))
        else $error("ring fill level beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_we && req == sbec_pkg::REQ_CLEAR) |=>
        (edge_held_reg == '0 && frame_held_reg == '0 && byte_held_reg == '0 &&
         drops_reg == '0 && !spi_reg))
        else $error("clear left state behind");

endmodule
